// ===== sv/ictf_pkg.sv =====
// ictf_pkg: shared types, constants and the arctangent table for the tilt filter
// used by every module of the imu complementary tilt filter
`default_nettype none

package ictf_pkg;

   localparam int ACC_W   = 16;
   localparam int US_W    = 20;
   localparam int ANG_W   = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_RANGE   = 4'd1;

   localparam logic [15:0] WEIGHT_RESET = 16'd62915;
   localparam logic [1:0]  RANGE_RESET  = 2'd0;

   localparam logic [US_W-1:0] US_MAX = 20'd1000000;

   // isqrt of a 48 bit value: 24 two-bit steps
   localparam int          ROOT_N_W   = 48;
   localparam logic [4:0]  ROOT_LAST  = 5'd23;

   // cordic datapath widths
   localparam int XY_W = 28;
   localparam int Z_W  = 25;

   // gyro scaling: 250/128e6 is 1/512000, so q = (|raw|*us<<range + 256000) / 512000
   // taken as >> 12, then / 125 by reciprocal multiply (ceil(2^33/125), exact below 2^26)
   localparam logic [37:0] GYRO_HALF    = 38'd256000;
   localparam logic [26:0] GYRO_RECIP   = 27'd68719477;
   localparam logic [4:0]  GYRO_LAST    = 5'd3;

   typedef enum logic [8:0] {
      S_IDLE        = 9'b000000001,
      S_SQUARE      = 9'b000000010,
      S_ROOT_INIT   = 9'b000000100,
      S_ROOT        = 9'b000001000,
      S_CORDIC_INIT = 9'b000010000,
      S_CORDIC      = 9'b000100000,
      S_BLEND_MUL   = 9'b001000000,
      S_BLEND_SUM   = 9'b010000000,
      S_DONE        = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic root_init;
      logic root_step;
      logic cordic_init;
      logic cordic_step;
      logic blend_mul;
      logic blend_sum;
      logic commit;
      logic sel;        // 0 roll, 1 pitch
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic cordic_last;
      logic gyro_done;
      logic out_free;
   } status_type;

   // rounded q16 degree arctangent of 2^-i
   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117266;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ictf_if.sv =====
// ictf channel interfaces: sample request, angle response, register write
// depends on ictf_pkg for field widths
`default_nettype none

interface ictf_req_if;
   logic valid;
   logic ready;
   logic signed [ictf_pkg::ACC_W-1:0] accel_x;
   logic signed [ictf_pkg::ACC_W-1:0] accel_y;
   logic signed [ictf_pkg::ACC_W-1:0] accel_z;
   logic signed [ictf_pkg::ACC_W-1:0] gyro_x;
   logic signed [ictf_pkg::ACC_W-1:0] gyro_y;
   logic signed [ictf_pkg::ACC_W-1:0] gyro_z;
   logic [ictf_pkg::US_W-1:0] elapsed_us;
   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   elapsed_us, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 elapsed_us, output ready);
endinterface

interface ictf_rsp_if;
   logic valid;
   logic ready;
   logic signed [ictf_pkg::ANG_W-1:0] roll_angle;
   logic signed [ictf_pkg::ANG_W-1:0] pitch_angle;
   logic signed [ictf_pkg::ANG_W-1:0] yaw_angle;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface ictf_csr_if;
   logic valid;
   logic ready;
   logic [ictf_pkg::CSR_IDX_W-1:0]  index;
   logic [ictf_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/imu_complementary_tilt_filter.sv =====
// imu_complementary_tilt_filter: roll/pitch complementary filter with yaw integration
//
// channels: req_port takes one imu word (three accel axes, three gyro axes,
// elapsed microseconds), rsp_port returns one word of roll, pitch and yaw in
// 1/256 degree, csr_port writes blend_weight (index 0) and gyro_range (index 1);
// csr_ready is always high.
// one word is worked at a time: req_ready is high only while idle. after the
// accept the block works through both angles before the result lands in the
// output register and req_ready returns; each angle runs a square root and a
// cordic on one shared unit, the gyro scaling runs alongside.
// a stalled rsp side holds the result in the output register; a next word may
// be accepted meanwhile and waits in its done state until the slot frees.
// reset (synchronous) clears the estimates, restores the registers to their
// defaults and empties the output register.
// depends on ictf_pkg, ictf_if, ictf_ctrl, ictf_dp
`default_nettype none

module imu_complementary_tilt_filter #(
   parameter int CORDIC_STEPS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   ictf_req_if.sink   req_port,
   ictf_rsp_if.source rsp_port,
   ictf_csr_if.sink   csr_port
);

   ictf_pkg::cmd_type    cmd;
   ictf_pkg::status_type status;

   assign csr_port.ready = 1'b1;

   ictf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ictf_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_port.valid),
      .csr_index   (csr_port.index),
      .csr_data    (csr_port.data),
      .accel_x     (req_port.accel_x),
      .accel_y     (req_port.accel_y),
      .accel_z     (req_port.accel_z),
      .gyro_x      (req_port.gyro_x),
      .gyro_y      (req_port.gyro_y),
      .gyro_z      (req_port.gyro_z),
      .elapsed_us  (req_port.elapsed_us),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_port.valid),
      .rsp_ready   (rsp_port.ready),
      .roll_angle  (rsp_port.roll_angle),
      .pitch_angle (rsp_port.pitch_angle),
      .yaw_angle   (rsp_port.yaw_angle)
   );

endmodule

`default_nettype wire

// ===== sv/ictf_ctrl.sv =====
// ictf_ctrl: sequencer for the tilt filter, one word at a time
// depends on ictf_pkg; drives the datapath through cmd_type
`default_nettype none

module ictf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ictf_pkg::status_type status,
   output ictf_pkg::cmd_type        cmd
);

   ictf_pkg::state_type state_ff, state_in;
   logic sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_ready = 1'b0;
      case (state_ff)
         ictf_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = 1'b0;
               state_in = ictf_pkg::S_SQUARE;
            end
         end
         ictf_pkg::S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ictf_pkg::S_ROOT_INIT;
         end
         ictf_pkg::S_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            state_in      = ictf_pkg::S_ROOT;
         end
         ictf_pkg::S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) state_in = ictf_pkg::S_CORDIC_INIT;
         end
         ictf_pkg::S_CORDIC_INIT: begin
            cmd.cordic_init = 1'b1;
            state_in        = ictf_pkg::S_CORDIC;
         end
         ictf_pkg::S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) state_in = ictf_pkg::S_BLEND_MUL;
         end
         ictf_pkg::S_BLEND_MUL: begin
            cmd.blend_mul = 1'b1;
            if (status.gyro_done) state_in = ictf_pkg::S_BLEND_SUM;
         end
         ictf_pkg::S_BLEND_SUM: begin
            cmd.blend_sum = 1'b1;
            if (sel_ff) begin
               state_in = ictf_pkg::S_DONE;
            end else begin
               sel_in   = 1'b1;
               state_in = ictf_pkg::S_ROOT_INIT;
            end
         end
         ictf_pkg::S_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ictf_pkg::S_IDLE;
            end
         end
         default: state_in = ictf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ictf_pkg::S_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ictf_dp.sv =====
// ictf_dp: datapath with squares, isqrt, cordic, gyro scaling, blend and output word
// depends on ictf_pkg; sequenced by ictf_ctrl
`default_nettype none

module ictf_dp #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [ictf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ictf_pkg::CSR_DATA_W-1:0]       csr_data,
   input  wire logic signed [ictf_pkg::ACC_W-1:0]     accel_x,
   input  wire logic signed [ictf_pkg::ACC_W-1:0]     accel_y,
   input  wire logic signed [ictf_pkg::ACC_W-1:0]     accel_z,
   input  wire logic signed [ictf_pkg::ACC_W-1:0]     gyro_x,
   input  wire logic signed [ictf_pkg::ACC_W-1:0]     gyro_y,
   input  wire logic signed [ictf_pkg::ACC_W-1:0]     gyro_z,
   input  wire logic [ictf_pkg::US_W-1:0]             elapsed_us,
   input  wire ictf_pkg::cmd_type                     cmd,
   output ictf_pkg::status_type                       status,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ictf_pkg::ANG_W-1:0]          roll_angle,
   output logic signed [ictf_pkg::ANG_W-1:0]          pitch_angle,
   output logic signed [ictf_pkg::ANG_W-1:0]          yaw_angle
);

   localparam int XY_W = ictf_pkg::XY_W;
   localparam int Z_W  = ictf_pkg::Z_W;
   localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

   // configuration
   logic [15:0] weight_ff;
   logic [1:0]  range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= ictf_pkg::WEIGHT_RESET;
         range_ff  <= ictf_pkg::RANGE_RESET;
      end else if (csr_we) begin
         if (csr_index == ictf_pkg::CSR_BLEND_WEIGHT) weight_ff <= csr_data[15:0];
         if (csr_index == ictf_pkg::CSR_GYRO_RANGE)   range_ff  <= csr_data[1:0];
      end
   end

   // sample latch
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] raw_ff [3];
   logic [19:0]        us_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff     <= accel_x;
         ay_ff     <= accel_y;
         az_ff     <= accel_z;
         raw_ff[0] <= gyro_x;
         raw_ff[1] <= gyro_y;
         raw_ff[2] <= gyro_z;
         us_ff     <= (elapsed_us > ictf_pkg::US_MAX) ? ictf_pkg::US_MAX : elapsed_us;
      end
   end

   // squares
   logic [30:0] sqx_ff, sqy_ff, sqz_ff;
   logic signed [31:0] px, py, pz;
   assign px = ax_ff * ax_ff;
   assign py = ay_ff * ay_ff;
   assign pz = az_ff * az_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sqx_ff <= px[30:0];
         sqy_ff <= py[30:0];
         sqz_ff <= pz[30:0];
      end
   end

   // integer square root, two bits a cycle
   logic [47:0] n_ff, root_ff, rbit_ff;
   logic [4:0]  root_cnt_ff;
   logic [31:0] ssum;
   logic [48:0] trial;

   assign ssum  = cmd.sel ? ({1'b0, sqy_ff} + {1'b0, sqz_ff})
                          : ({1'b0, sqx_ff} + {1'b0, sqz_ff});
   assign trial = {1'b0, root_ff} + {1'b0, rbit_ff};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         n_ff        <= {ssum[31:0], 16'd0};
         root_ff     <= '0;
         rbit_ff     <= 48'd1 << 46;
         root_cnt_ff <= '0;
      end else if (cmd.root_step) begin
         if ({1'b0, n_ff} >= trial) begin
            n_ff    <= n_ff - trial[47:0];
            root_ff <= (root_ff >> 1) + rbit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         rbit_ff     <= rbit_ff >> 2;
         root_cnt_ff <= root_cnt_ff + 5'd1;
      end
   end

   // cordic vectoring
   logic signed [XY_W-1:0] x_ff, y_ff, xs, ys;
   logic signed [Z_W-1:0]  z_ff, atan_v;
   logic [4:0]             idx_ff;
   logic                   zero_ff;
   logic signed [16:0]     num;

   assign num    = cmd.sel ? -17'(ax_ff) : 17'(ay_ff);
   assign xs     = x_ff >>> idx_ff;
   assign ys     = y_ff >>> idx_ff;
   assign atan_v = $signed({3'b000, ictf_pkg::atan_q16(idx_ff)});

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         x_ff    <= $signed({4'd0, root_ff[23:0]});
         y_ff    <= XY_W'($signed({num, 8'd0}));
         z_ff    <= '0;
         idx_ff  <= '0;
         zero_ff <= (root_ff[23:0] == 24'd0) && (num == 17'sd0);
      end else if (cmd.cordic_step) begin
         if (!y_ff[XY_W-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_v;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_v;
         end
         idx_ff <= idx_ff + 5'd1;
      end
   end

   // gyro increments, three lanes: product, round and shift, reciprocal multiply
   logic [4:0]  gcnt_ff;
   logic [35:0] gm_ff [3];
   logic [25:0] ghi_ff [3];
   logic [19:0] gq_ff [3];
   logic        gneg [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         gcnt_ff <= '0;
      end else if (cmd.load) begin
         gcnt_ff <= 5'd1;
      end else if (gcnt_ff != 5'd0) begin
         gcnt_ff <= (gcnt_ff == ictf_pkg::GYRO_LAST) ? 5'd0 : gcnt_ff + 5'd1;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [15:0] absv;
      logic [37:0] biased;
      logic [52:0] prod;

      assign gneg[i] = raw_ff[i][15];
      assign absv    = gneg[i] ? (~raw_ff[i] + 16'd1) : raw_ff[i];
      assign biased  = (38'(gm_ff[i]) << range_ff) + ictf_pkg::GYRO_HALF;
      assign prod    = 53'(ghi_ff[i]) * 53'(ictf_pkg::GYRO_RECIP);

      always_ff @(posedge clock) begin
         if (gcnt_ff == 5'd1) begin
            gm_ff[i] <= 36'(absv) * 36'(us_ff);
         end
         if (gcnt_ff == 5'd2) begin
            ghi_ff[i] <= biased[37:12];
         end
         if (gcnt_ff == 5'd3) begin
            gq_ff[i] <= prod[52:33];
         end
      end
   end

   // signed increments, roll and pitch flip when accel_z is negative
   logic signed [20:0] g_roll, g_pitch, g_yaw;
   assign g_roll  = (gneg[0] ^ az_ff[15]) ? -$signed({1'b0, gq_ff[0]}) : $signed({1'b0, gq_ff[0]});
   assign g_pitch = (gneg[1] ^ az_ff[15]) ? -$signed({1'b0, gq_ff[1]}) : $signed({1'b0, gq_ff[1]});
   assign g_yaw   = gneg[2] ? -$signed({1'b0, gq_ff[2]}) : $signed({1'b0, gq_ff[2]});

   // blend
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff, new_roll_ff, new_pitch_ff;
   logic signed [47:0] prod1_ff;
   logic signed [41:0] prod2_ff;
   logic signed [31:0] t;
   logic signed [Z_W-1:0] a16;
   logic [16:0]        wc;
   logic signed [57:0] acc;

   assign t   = (cmd.sel ? pitch_ff : roll_ff) + 32'(cmd.sel ? g_pitch : g_roll);
   assign a16 = zero_ff ? '0 : z_ff;
   assign wc  = 17'h10000 - {1'b0, weight_ff};
   assign acc = (58'(prod1_ff) <<< 8) + 58'(prod2_ff) + 58'sd8388608;

   always_ff @(posedge clock) begin
      if (cmd.blend_mul) begin
         prod1_ff <= t * $signed({1'b0, weight_ff});
         prod2_ff <= a16 * $signed({1'b0, wc});
      end
      if (cmd.blend_sum) begin
         if (cmd.sel) new_pitch_ff <= acc[55:24];
         else         new_roll_ff  <= acc[55:24];
      end
   end

   // estimates and output word
   logic rsp_valid_ff;
   logic signed [31:0] yaw_next;
   assign yaw_next = yaw_ff + 32'(g_yaw);

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         roll_ff      <= new_roll_ff;
         pitch_ff     <= new_pitch_ff;
         yaw_ff       <= yaw_next;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   logic signed [31:0] out_roll_ff, out_pitch_ff, out_yaw_ff;
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_roll_ff  <= new_roll_ff;
         out_pitch_ff <= new_pitch_ff;
         out_yaw_ff   <= yaw_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign roll_angle  = out_roll_ff;
   assign pitch_angle = out_pitch_ff;
   assign yaw_angle   = out_yaw_ff;

   assign status.root_last   = root_cnt_ff == ictf_pkg::ROOT_LAST;
   assign status.cordic_last = idx_ff == CORDIC_LAST;
   assign status.gyro_done   = gcnt_ff == 5'd0;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ===== sv/ictf_checker.sv =====
// ictf_checker: port-level checks on the tilt filter over time
// bound to imu_complementary_tilt_filter; depends on ictf_pkg widths
`default_nettype none

module ictf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [ictf_pkg::ANG_W-1:0] roll_angle,
   input wire logic signed [ictf_pkg::ANG_W-1:0] yaw_angle
);

   // output register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one word in flight: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
      else $error("req accepted while busy");

   // a new result only appears out of a busy cycle
   a_new_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without work");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(roll_angle) && $stable(yaw_angle))
      else $error("stalled result changed");

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .roll_angle (rsp_port.roll_angle),
   .yaw_angle  (rsp_port.yaw_angle)
);

`default_nettype wire

// ===== tb/sv/imu_complementary_tilt_filter_tb.sv =====
// imu_complementary_tilt_filter_tb: self-checking bench for the tilt filter,
// drives imu words with random idling and checks every angle word against a predictor
// depends on ictf_pkg, ictf_if and the imu_complementary_tilt_filter rtl
`default_nettype none

module imu_complementary_tilt_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TILT_STEPS   = 16;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam int LONG_HOLD    = 400;

   // indexes with no register behind them
   localparam logic [ictf_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 4'd2;
   localparam logic [ictf_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 4'd15;

   typedef struct {
      logic signed [ictf_pkg::ACC_W-1:0] ax, ay, az, gx, gy, gz;
      logic [ictf_pkg::US_W-1:0]         us;
   } imu_word_type;

   typedef struct {
      logic signed [ictf_pkg::ANG_W-1:0] roll, pitch, yaw;
   } angle_word_type;

   // q16 degree arctangent of 2^-i
   localparam longint ATAN_STEP [0:15] = '{
      2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};

   class tilt_scoreboard;
      logic [15:0] weight;
      logic [1:0]  range;
      logic [31:0] roll_est, pitch_est, yaw_est;
      angle_word_type pending[$];
      int          errors;

      function new();
         weight = ictf_pkg::WEIGHT_RESET;
         range = ictf_pkg::RANGE_RESET;
         roll_est = 0;
         pitch_est = 0;
         yaw_est = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [ictf_pkg::CSR_IDX_W-1:0] idx,
                              logic [ictf_pkg::CSR_DATA_W-1:0] data);
         if (idx == ictf_pkg::CSR_BLEND_WEIGHT) weight = data;
         else if (idx == ictf_pkg::CSR_GYRO_RANGE) range = data[1:0];
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      // atan2(num, sqrt(p^2+q^2)) in q16 degrees
      function longint accel_tilt(longint num, longint p, longint q);
         longint x, y, z, xs, ys;
         longint unsigned s;
         s = p * p + q * q;
         x = int_sqrt(s << 16);
         y = num * 256;
         z = 0;
         if (x == 0 && y == 0) return 0;
         for (int i = 0; i < TILT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_STEP[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_STEP[i];
            end
         end
         return z;
      endfunction

      function longint gyro_delta(longint raw, longint us);
         longint fs, mag, r;
         fs = 250 << range;
         mag = (raw < 0 ? -raw : raw) * fs * us;
         r = (mag + 64000000) / 128000000;
         return raw < 0 ? -r : r;
      endfunction

      function logic [31:0] mix(logic [31:0] est, longint g, longint a16);
         logic [31:0] sum;
         longint t, w, acc;
         sum = est + g[31:0];
         t = longint'($signed(sum));
         w = weight;
         acc = t * w * 256 + a16 * (65536 - w) + (64'sd1 <<< 23);
         acc = acc >>> 24;
         return acc[31:0];
      endfunction

      function void note_word(imu_word_type wd);
         longint us, a_roll, a_pitch, g_roll, g_pitch, g_yaw;
         angle_word_type e;
         us = wd.us;
         if (us > 1000000) us = 1000000;
         a_roll = accel_tilt(wd.ay, wd.ax, wd.az);
         a_pitch = accel_tilt(-longint'(wd.ax), wd.ay, wd.az);
         g_roll = gyro_delta(wd.gx, us);
         g_pitch = gyro_delta(wd.gy, us);
         g_yaw = gyro_delta(wd.gz, us);
         if (wd.az < 0) begin
            g_roll = -g_roll;
            g_pitch = -g_pitch;
         end
         roll_est = mix(roll_est, g_roll, a_roll);
         pitch_est = mix(pitch_est, g_pitch, a_pitch);
         yaw_est = yaw_est + g_yaw[31:0];
         e.roll = roll_est;
         e.pitch = pitch_est;
         e.yaw = yaw_est;
         pending.push_back(e);
      endfunction

      function void check_angles(angle_word_type got);
         angle_word_type e;
         if (pending.size() == 0) begin
            $error("angle word with nothing pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.roll !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", e.roll, got.roll);
            errors++;
         end
         if (got.pitch !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, got.pitch);
            errors++;
         end
         if (got.yaw !== e.yaw) begin
            $error("yaw_angle expected %0d actual %0d", e.yaw, got.yaw);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;

   ictf_req_if req_if();
   ictf_rsp_if rsp_if();
   ictf_csr_if csr_if();

   imu_complementary_tilt_filter dut (
      .clock(clock), .reset(reset),
      .req_port(req_if), .rsp_port(rsp_if), .csr_port(csr_if)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   tilt_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   initial begin
      req_if.valid = 0;
      req_if.accel_x = 0;
      req_if.accel_y = 0;
      req_if.accel_z = 0;
      req_if.gyro_x = 0;
      req_if.gyro_y = 0;
      req_if.gyro_z = 0;
      req_if.elapsed_us = 0;
      rsp_if.ready = 0;
      csr_if.valid = 0;
      csr_if.index = 0;
      csr_if.data = 0;
   end

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      angle_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.roll = rsp_if.roll_angle;
         got.pitch = rsp_if.pitch_angle;
         got.yaw = rsp_if.yaw_angle;
         sb.check_angles(got);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(imu_word_type wd);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.accel_x <= wd.ax;
      req_if.accel_y <= wd.ay;
      req_if.accel_z <= wd.az;
      req_if.gyro_x <= wd.gx;
      req_if.gyro_y <= wd.gy;
      req_if.gyro_z <= wd.gz;
      req_if.elapsed_us <= wd.us;
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(wd);
   endtask

   // one write, then an idle gap so back to back writes never collide
   task automatic write_csr(logic [ictf_pkg::CSR_IDX_W-1:0] idx,
                            logic [ictf_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // pause the sender until every angle word is back, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic imu_word_type make_word(longint ax, longint ay, longint az,
                                              longint gx, longint gy, longint gz,
                                              longint us);
      imu_word_type wd;
      wd.ax = ax[15:0];
      wd.ay = ay[15:0];
      wd.az = az[15:0];
      wd.gx = gx[15:0];
      wd.gy = gy[15:0];
      wd.gz = gz[15:0];
      wd.us = us[19:0];
      return wd;
   endfunction

   function automatic longint spread(int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // mostly a sensor at rest or slowly tilting, the rest raw noise
   function automatic imu_word_type random_word();
      longint az;
      if ($urandom_range(0, 99) < 25)
         return make_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
      az = $urandom_range(8000, 20000);
      if ($urandom_range(0, 3) == 0) az = -az;
      return make_word(spread(9000), spread(9000), az, spread(3000), spread(3000),
                       spread(3000),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575)
                                                   : $urandom_range(200, 20000));
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_word(random_word());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 49;
      // field extremes, zero vector, negative z, saturated time
      send_word(make_word(0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(0, 0, 0, 32767, -32768, 32767, 1000000));
      send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 1000000));
      send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, 1048575));
      send_word(make_word(-32768, 32767, -1, 1000, -1000, 5, 1000001));
      send_word(make_word(32767, -32768, 0, -1, 1, -1, 1));
      send_word(make_word(0, 0, 16384, 100, 200, 300, 1000));
      send_word(make_word(0, 0, -16384, 100, 200, 300, 1000));
      send_word(make_word(16384, 0, 0, 0, 0, 0, 999999));
      send_word(make_word(0, -16384, 0, 0, 0, 0, 524288));
      send_word(make_word(1, 1, 1, 1, 1, 1, 64));
      send_word(make_word(-1, -1, -1, -1, -1, -1, 63));
      run_random(280);
      drain();

      write_csr(ictf_pkg::CSR_BLEND_WEIGHT, 16'd0);
      write_csr(ictf_pkg::CSR_GYRO_RANGE, 16'hFFFF);
      write_csr(CSR_UNUSED_LO, 16'h1234);
      write_csr(CSR_UNUSED_HI, 16'hFFFF);
      send_idle_pct = 49;
      recv_idle_pct = 28;
      send_word(make_word(32767, -32768, 1000, 32767, -32768, 32767, 1000000));
      send_word(make_word(0, 0, 0, 0, 0, 0, 1000000));
      run_random(280);
      drain();

      write_csr(ictf_pkg::CSR_BLEND_WEIGHT, 16'hFFFF);
      write_csr(ictf_pkg::CSR_GYRO_RANGE, 16'd1);
      send_word(make_word(-32768, -32768, -32768, 32767, 32767, -32768, 1048575));
      run_random(280);
      drain();

      write_csr(ictf_pkg::CSR_BLEND_WEIGHT, 16'($urandom));
      write_csr(ictf_pkg::CSR_GYRO_RANGE, 16'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(100);
      hold_request = 1;
      run_random(180);
      drain();

      write_csr(ictf_pkg::CSR_BLEND_WEIGHT, ictf_pkg::WEIGHT_RESET);
      write_csr(ictf_pkg::CSR_GYRO_RANGE,
                {14'd0, 2'($urandom_range(0, 3))} | (16'hFFFC & 16'($urandom)));
      run_random(300);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

`default_nettype wire
